// ----- src/mrf_pkg.sv -----
// shared types, sizes and codes for the message ring fifo
package mrf_pkg;

    localparam int SLOT_COUNT        = 16;
    localparam int MAX_PAYLOAD_BYTES = 56;

    localparam int POS_RANGE   = 2 * SLOT_COUNT;
    localparam int POS_W       = $clog2(POS_RANGE);
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int HELD_W      = $clog2(SLOT_COUNT + 1);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD_BYTES + 2);
    localparam int STORE_DEPTH = SLOT_COUNT * MAX_PAYLOAD_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CAP_FIELD_W = 6;
    localparam int LEN_FIELD_W = 6;
    localparam int OCC_FIELD_W = 5;

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_POP     = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd3;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [7:0]             data_byte;
        logic                   byte_present;
        logic                   end_of_message;
        logic [CAP_FIELD_W-1:0] reader_capacity;
    } request_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [7:0]             out_byte;
        logic                   byte_valid;
        logic                   last;
        logic [LEN_FIELD_W-1:0] message_length;
        logic [OCC_FIELD_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } len_wr_t;

endpackage

// ----- src/mrf_payload_ram.sv -----
// payload byte store, one write port and one registered read port
module mrf_payload_ram (
    input  logic            clk,
    input  mrf_pkg::ram_wr_t wr,
    input  mrf_pkg::ram_rd_t rd,
    output logic [7:0]      rd_data
);
    import mrf_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/mrf_length_table.sv -----
// per-slot message length table
module mrf_length_table (
    input  logic                        clk,
    input  mrf_pkg::len_wr_t            wr,
    input  logic [mrf_pkg::SLOT_W-1:0]  rd_slot,
    output logic [mrf_pkg::LEN_W-1:0]   rd_len
);
    import mrf_pkg::*;

    logic [LEN_W-1:0] lengths_reg [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lengths_reg[wr.slot] <= wr.len;
        end
    end

    assign rd_len = lengths_reg[rd_slot];

endmodule

// ----- src/message_ring_fifo.sv -----
// message ring fifo top level: request decode, ring pointers and result register
// every request that yields a result shows its first result in the cycle after acceptance
// push, release and short results: one request per cycle, busy stays low
// pop or peek of an n-byte message: n results on consecutive cycles, set by the
//   single read port of the payload store; busy is high until the last of them appears
// reset: pointers and incoming message state clear at once, stores need no clearing
// the receiver cannot stall: each result is on the ports for exactly one cycle
module message_ring_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mrf_pkg::request_t request,
    output logic              busy,
    output logic              result_strobe,
    output mrf_pkg::result_t  result
);
    import mrf_pkg::*;

    localparam int CMP_W = (LEN_W > CAP_FIELD_W) ? LEN_W : CAP_FIELD_W;

    // ring pointers count modulo twice the slot count
    function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] p);
        logic [POS_W:0] n;
        n = {1'b0, p} + 1'b1;
        if (n >= (POS_W + 1)'(POS_RANGE))
        begin
            pos_advance = '0;
        end
        else
        begin
            pos_advance = n[POS_W-1:0];
        end
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [POS_W-1:0] p);
        if (p >= POS_W'(SLOT_COUNT))
        begin
            slot_of = SLOT_W'(p - POS_W'(SLOT_COUNT));
        end
        else
        begin
            slot_of = SLOT_W'(p);
        end
    endfunction

    // control state
    logic [POS_W-1:0]  wp_reg, wp_next;
    logic [POS_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              blocked_reg, blocked_next;
    logic              within_reg, within_next;
    logic              stream_reg, stream_next;
    logic              strobe_reg, strobe_next;

    // payload state
    logic [LEN_W-1:0]  tail_len_reg, tail_len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  slen_reg, slen_next;
    logic [ADDR_W-1:0] sbase_reg, sbase_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic [HELD_W-1:0] held;
    logic [LEN_W-1:0]  tail_now;
    logic [SLOT_W-1:0] wslot;
    logic [POS_W-1:0]  rp_adv;
    logic [LEN_W-1:0]  next_len;
    logic [ADDR_W-1:0] wbase;
    logic [ADDR_W-1:0] rbase;
    logic [7:0]        rd_data;

    // per-request scratch for the push path
    logic              first;
    logic              blocked_eff;
    logic [CNT_W-1:0]  count_eff;
    logic [CNT_W-1:0]  count_new;

    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    len_wr_t           len_wr;

    assign accept = start && !busy;
    assign busy   = stream_reg;

    // messages held: pointer difference modulo the pointer range
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            held = HELD_W'(wp_reg - rp_reg);
        end
        else
        begin
            held = HELD_W'({1'b0, wp_reg} + (POS_W + 1)'(POS_RANGE) - {1'b0, rp_reg});
        end
    end

    assign tail_now = (held == '0) ? '0 : tail_len_reg;
    assign wslot    = slot_of(wp_reg);
    assign rp_adv   = pos_advance(rp_reg);
    assign wbase    = ADDR_W'(wslot) * ADDR_W'(MAX_PAYLOAD_BYTES);
    assign rbase    = ADDR_W'(slot_of(rp_reg)) * ADDR_W'(MAX_PAYLOAD_BYTES);

    mrf_payload_ram u_payload (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (rd_data)
    );

    // length of the message that becomes the tail once the read pointer moves
    mrf_length_table u_lengths (
        .clk     (clk),
        .wr      (len_wr),
        .rd_slot (slot_of(rp_adv)),
        .rd_len  (next_len)
    );

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        count_next    = count_reg;
        blocked_next  = blocked_reg;
        within_next   = within_reg;
        stream_next   = stream_reg;
        strobe_next   = 1'b0;
        tail_len_next = tail_len_reg;
        idx_next      = idx_reg;
        slen_next     = slen_reg;
        sbase_next    = sbase_reg;
        result_next   = result_reg;
        ram_wr        = '0;
        ram_rd        = '0;
        len_wr        = '0;
        first         = !within_reg;
        blocked_eff   = blocked_reg;
        count_eff     = count_reg;
        count_new     = count_reg;

        if (stream_reg)
        begin
            // next byte of a pop or peek in flight
            ram_rd.en        = 1'b1;
            ram_rd.addr      = sbase_reg + ADDR_W'(idx_reg);
            strobe_next      = 1'b1;
            result_next.last = (({1'b0, idx_reg} + 1'b1) == {1'b0, slen_reg});
            idx_next         = idx_reg + 1'b1;
            stream_next      = !result_next.last;
        end
        else if (accept)
        begin
            unique case (request.req_type) inside
                REQ_PUSH:
                begin
                    if (request.byte_present || request.end_of_message)
                    begin
                        // fullness is judged on the first item of a message
                        blocked_eff = first ? (held >= HELD_W'(SLOT_COUNT)) : blocked_reg;
                        count_eff   = first ? '0 : count_reg;
                        count_new   = count_eff;
                        if (request.byte_present)
                        begin
                            if (count_eff < CNT_W'(MAX_PAYLOAD_BYTES))
                            begin
                                ram_wr.en   = !blocked_eff;
                                ram_wr.addr = wbase + ADDR_W'(count_eff);
                                ram_wr.data = request.data_byte;
                                count_new   = count_eff + 1'b1;
                            end
                            else
                            begin
                                // oversized: saturate one past the limit
                                count_new = CNT_W'(MAX_PAYLOAD_BYTES + 1);
                            end
                        end
                        if (request.end_of_message)
                        begin
                            within_next  = 1'b0;
                            count_next   = '0;
                            blocked_next = 1'b0;
                            strobe_next  = 1'b1;
                            result_next  = '0;
                            result_next.last      = 1'b1;
                            result_next.occupancy = OCC_FIELD_W'(held);
                            result_next.message_length = LEN_FIELD_W'(tail_now);
                            if (count_new > CNT_W'(MAX_PAYLOAD_BYTES))
                            begin
                                result_next.status = STATUS_TOO_BIG;
                            end
                            else if (blocked_eff)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                // publish the message in the head slot
                                len_wr.en   = 1'b1;
                                len_wr.slot = wslot;
                                len_wr.len  = LEN_W'(count_new);
                                wp_next     = pos_advance(wp_reg);
                                result_next.status    = STATUS_OK;
                                result_next.occupancy = OCC_FIELD_W'(held + 1'b1);
                                if (held == '0)
                                begin
                                    tail_len_next = LEN_W'(count_new);
                                    result_next.message_length = LEN_FIELD_W'(count_new);
                                end
                            end
                        end
                        else
                        begin
                            within_next  = 1'b1;
                            count_next   = count_new;
                            blocked_next = blocked_eff;
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    strobe_next      = 1'b1;
                    result_next      = '0;
                    result_next.last = 1'b1;
                    if (held == '0)
                    begin
                        result_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        rp_next       = rp_adv;
                        tail_len_next = next_len;
                        result_next.status    = STATUS_OK;
                        result_next.occupancy = OCC_FIELD_W'(held - 1'b1);
                        result_next.message_length =
                            (held == HELD_W'(1)) ? '0 : LEN_FIELD_W'(next_len);
                    end
                end
                REQ_POP, REQ_PEEK:
                begin
                    strobe_next = 1'b1;
                    result_next = '0;
                    if (held == '0)
                    begin
                        result_next.status = STATUS_EMPTY;
                        result_next.last   = 1'b1;
                    end
                    else if (CMP_W'(tail_len_reg) > CMP_W'(request.reader_capacity))
                    begin
                        // reader room short: report length, keep the message
                        result_next.status         = STATUS_TOO_BIG;
                        result_next.last           = 1'b1;
                        result_next.message_length = LEN_FIELD_W'(tail_len_reg);
                        result_next.occupancy      = OCC_FIELD_W'(held);
                    end
                    else
                    begin
                        result_next.status         = STATUS_OK;
                        result_next.message_length = LEN_FIELD_W'(tail_len_reg);
                        result_next.occupancy      = OCC_FIELD_W'(held);
                        if (request.req_type == REQ_POP)
                        begin
                            rp_next       = rp_adv;
                            tail_len_next = next_len;
                            result_next.occupancy = OCC_FIELD_W'(held - 1'b1);
                        end
                        if (tail_len_reg == '0)
                        begin
                            result_next.last = 1'b1;
                        end
                        else
                        begin
                            // first byte read now, the rest streams from the counter
                            ram_rd.en              = 1'b1;
                            ram_rd.addr            = rbase;
                            sbase_next             = rbase;
                            slen_next              = tail_len_reg;
                            idx_next               = LEN_W'(1);
                            result_next.byte_valid = 1'b1;
                            result_next.last       = (tail_len_reg == LEN_W'(1));
                            stream_next            = (tail_len_reg != LEN_W'(1));
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            count_reg   <= '0;
            blocked_reg <= 1'b0;
            within_reg  <= 1'b0;
            stream_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            count_reg   <= count_next;
            blocked_reg <= blocked_next;
            within_reg  <= within_next;
            stream_reg  <= stream_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_len_reg <= tail_len_next;
        idx_reg      <= idx_next;
        slen_reg     <= slen_next;
        sbase_reg    <= sbase_next;
        result_reg   <= result_next;
    end

    // the byte comes straight from the store's read register
    always_comb
    begin
        result          = result_reg;
        result.out_byte = result_reg.byte_valid ? rd_data : 8'd0;
    end

    assign result_strobe = strobe_reg;

    // a byte stream always delivers a result in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) stream_reg |=> strobe_reg)
        else $error("byte stream dropped a result");

    // the stream index stays inside the message being delivered
    assert property (@(posedge clk) disable iff (!rst_n) stream_reg |-> (idx_reg < slen_reg))
        else $error("stream index beyond message length");

    // a result without a byte is always the final one of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !result.byte_valid) |-> result.last)
        else $error("byte-less result not marked last");

    // the ring never holds more messages than slots
    assert property (@(posedge clk) disable iff (!rst_n) held <= HELD_W'(SLOT_COUNT))
        else $error("ring occupancy exceeds slot count");

endmodule
